// ----- hdl/etbd_pkg.sv -----
package etbd_pkg;

	// reset value of the holdoff register
	localparam logic [7:0] HOLDOFF_RESET = 8'd10;
	// trigger byte above this marks the idle line as on
	localparam logic [7:0] ON_THRESHOLD  = 8'd128;
	// cable decode constants
	localparam logic [7:0] CODE_MASK     = 8'h3c;
	localparam logic [7:0] IDLE_OFFSET   = 8'd3;

	// one input frame
	typedef struct packed {
		logic [7:0] trigger_byte;
		logic [7:0] button_byte;
		logic       last_frame;
	} item_t;

	// one result
	typedef struct packed {
		logic [31:0]       frame_index;
		logic              trigger_seen;
		logic signed [7:0] trigger_code;
		logic              button_seen;
	} result_t;

	// cable formula, all arithmetic modulo 256
	function automatic logic signed [7:0] decode_code(input logic [7:0] t,
			input logic [7:0] idle);
		logic [7:0] a;
		logic [7:0] r;
		a = (t - (idle - IDLE_OFFSET)) & CODE_MASK;
		r = (a << 1) - t + idle;
		return $signed(r);
	endfunction

endpackage

// ----- hdl/etbd_in_if.sv -----
interface etbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] trigger_byte;
	logic [7:0] button_byte;
	logic       last_frame;

	modport source(output valid, output trigger_byte, output button_byte,
		output last_frame, input ready);
	modport sink(input valid, input trigger_byte, input button_byte,
		input last_frame, output ready);
endinterface

// ----- hdl/etbd_out_if.sv -----
interface etbd_out_if;
	logic              valid;
	logic              ready;
	logic [31:0]       frame_index;
	logic              trigger_seen;
	logic signed [7:0] trigger_code;
	logic              button_seen;

	modport source(output valid, output frame_index, output trigger_seen,
		output trigger_code, output button_seen, input ready);
	modport sink(input valid, input frame_index, input trigger_seen,
		input trigger_code, input button_seen, output ready);
endinterface

// ----- hdl/eeg_trigger_and_button_detector_core.sv -----
// EEG trigger and push-button event detector.
// Input channel in_ch carries one sampled frame per item: trigger byte,
// button byte and a last-frame mark. Output channel out_ch returns exactly
// one result per item: frame index, trigger onset flag with decoded code,
// and an accepted button press flag. Both channels use valid/ready; an item
// moves when both are high.
// From input acceptance to a valid result, an item passes one input register,
// then detection logic against the recording state, then the result register.
// Throughput is one item per cycle while the receiver does not stall; the state
// is updated in the same cycle an item leaves the input register.
// cfg_we/cfg_wdata write the holdoff frame count; write it only while
// the block is idle.
// Reset clears the recording state and both valid flags, and sets the holdoff
// to 10 frames; the block is ready in the first cycle after reset.
// When the receiver stalls, the result waits in the output register and one
// more item is taken into the input register; the input then stalls.
// A frame marked last returns the recording state to its reset values.
module eeg_trigger_and_button_detector_core #(
	parameter int FRAME_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	etbd_in_if.sink    in_ch,
	etbd_out_if.source out_ch
);
	import etbd_pkg::*;

	logic [7:0] holdoff_frames_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	logic       advance;
	logic       in_ready;

	// holdoff register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_frames_q <= HOLDOFF_RESET;
		end else if (cfg_we) begin
			holdoff_frames_q <= cfg_wdata;
		end
	end

	// flow control
	assign advance  = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_ch.ready = in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			item_s1.trigger_byte <= in_ch.trigger_byte;
			item_s1.button_byte  <= in_ch.button_byte;
			item_s1.last_frame   <= in_ch.last_frame;
		end
	end

	// detection against recording state
	etbd_detect #(
		.FRAME_BITS(FRAME_BITS)
	) u_detect (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.holdoff (holdoff_frames_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.frame_index  = res_q.frame_index;
	assign out_ch.trigger_seen = res_q.trigger_seen;
	assign out_ch.trigger_code = res_q.trigger_code;
	assign out_ch.button_seen  = res_q.button_seen;

`ifndef NO_ASSERTIONS
	// a held item in the input register is never dropped
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input item lost while stalled");

	// a stalled result is never overwritten
	a_res_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !advance)
		else $error("result overwritten while stalled");

	// code is zero unless a trigger onset is reported
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.trigger_seen |-> res_q.trigger_code == 8'sd0)
		else $error("trigger code set without onset");
`endif
endmodule

// ----- hdl/etbd_detect.sv -----
module etbd_detect #(
	parameter int FRAME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  etbd_pkg::item_t  item,
	input  logic [7:0]       holdoff,
	output etbd_pkg::result_t res
);
	import etbd_pkg::*;

	logic [FRAME_BITS-1:0] frame_counter_q;
	logic [FRAME_BITS-1:0] last_change_frame_q;
	logic [7:0]            idle_code_q;
	logic [7:0]            prev_button_q;
	logic                  started_q;
	logic                  prev_trigger_on_q;
	logic                  button_held_q;
	logic                  change_recorded_q;

	logic                  trig_on;
	logic                  trig_seen;
	logic                  btn_change;
	logic [FRAME_BITS-1:0] change_gap;
	logic                  holdoff_ok;
	logic                  btn_seen;

	// trigger onset and button change detection
	always_comb begin
		trig_on    = item.trigger_byte != idle_code_q;
		trig_seen  = started_q && trig_on && !prev_trigger_on_q;
		btn_change = item.button_byte != prev_button_q;
		change_gap = frame_counter_q - last_change_frame_q;
		holdoff_ok = !change_recorded_q || (change_gap > FRAME_BITS'(holdoff));
		btn_seen   = started_q && btn_change && !button_held_q && holdoff_ok;
	end

	// result for the current item
	always_comb begin
		res.frame_index  = 32'(frame_counter_q);
		res.trigger_seen = trig_seen;
		res.trigger_code = trig_seen ? decode_code(item.trigger_byte, idle_code_q) : '0;
		res.button_seen  = btn_seen;
	end

	// recording state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q     <= '0;
			last_change_frame_q <= '0;
			idle_code_q         <= '0;
			prev_button_q       <= '0;
			started_q           <= 1'b0;
			prev_trigger_on_q   <= 1'b0;
			button_held_q       <= 1'b0;
			change_recorded_q   <= 1'b0;
		end else if (advance) begin
			if (item.last_frame) begin
				frame_counter_q     <= '0;
				last_change_frame_q <= '0;
				idle_code_q         <= '0;
				prev_button_q       <= '0;
				started_q           <= 1'b0;
				prev_trigger_on_q   <= 1'b0;
				button_held_q       <= 1'b0;
				change_recorded_q   <= 1'b0;
			end else begin
				frame_counter_q <= frame_counter_q + FRAME_BITS'(1);
				prev_button_q   <= item.button_byte;
				if (!started_q) begin
					started_q         <= 1'b1;
					idle_code_q       <= item.trigger_byte;
					prev_trigger_on_q <= item.trigger_byte > ON_THRESHOLD;
				end else begin
					prev_trigger_on_q <= trig_on;
					if (btn_change) begin
						if (!button_held_q) begin
							button_held_q       <= holdoff_ok;
							last_change_frame_q <= frame_counter_q;
							change_recorded_q   <= 1'b1;
						end
					end else begin
						button_held_q <= 1'b0;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// the last frame of a recording rewinds to the first-frame state
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.last_frame |=> !started_q && frame_counter_q == '0)
		else $error("state not cleared after last frame");

	// an accepted press blocks further presses until released
	a_press_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item.last_frame && btn_seen |=> button_held_q)
		else $error("button not held after accepted press");

	// the first frame of a recording reports no event
	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !started_q |-> !res.trigger_seen && !res.button_seen)
		else $error("event reported on first frame");
`endif
endmodule
